// ----- sv/double_ended_queue_assert.svh -----
// Assertion macros shared by the double-ended queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dq_pkg.sv -----
// Package for the double-ended queue: action and status codes, the cell
// control struct and the default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH      = 64;
  localparam int DQ_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_FROM_LFT = 2'd1,
    CELL_FROM_RGT = 2'd2,
    CELL_LOAD     = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tap;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/dq_cell.sv -----
// One storage cell of the double-ended queue chain.
// Depends on dq_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module dq_cell #(
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input  wire logic                   clk,
  input  wire dq_pkg::cell_ctrl_t     ctrl,
  input  wire logic [DATA_WIDTH-1:0]  left_word,
  input  wire logic [DATA_WIDTH-1:0]  right_word,
  input  wire logic [DATA_WIDTH-1:0]  push_word,
  output logic      [DATA_WIDTH-1:0]  word,
  output logic      [DATA_WIDTH-1:0]  tap_word
);
  import dq_pkg::*;

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    case (ctrl.op)
      CELL_FROM_LFT: word_nxt = left_word;
      CELL_FROM_RGT: word_nxt = right_word;
      CELL_LOAD:     word_nxt = push_word;
      default:       word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  // A tapped cell offers its word to the pop read-out; others give zero.
  assign tap_word = ctrl.tap ? word_r : '0;

endmodule

`default_nettype wire

// ----- sv/double_ended_queue.sv -----
// Double-ended queue built as a chain of storage cells with a registered
// result stage. Depends on dq_pkg, dq_cell and double_ended_queue_assert.svh.
//
// Usage:
//   The input channel (in_valid, in_stall, in_action, in_push_word) carries
//   one request per accepted item: push at front, push at back, pop from
//   front or pop from back. Every request yields exactly one result on the
//   output channel (out_valid, out_stall, out_popped_word, out_status,
//   out_occupancy): the popped word (zero for pushes and failed pops), a
//   status (ok, pop on empty, push on full) and the word count afterwards.
//   The front of the queue always sits in cell 0 and the back in cell
//   count-1. A push at the front shifts every cell one place toward the back,
//   a pop from the front shifts every cell one place toward the front, and
//   the back end is written or read in place at the cell the count selects.
//   The result of an accepted request is on the output register in the next
//   cycle. Throughput is one request per cycle while out_stall is low: a new
//   request is taken in the same cycle that the previous result drains.
//   When the receiver stalls, the result register holds its value and
//   in_stall rises, so no request is accepted until the result drains.
//   Reset empties the queue and drops any pending result; cells need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DQ_DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire dq_pkg::action_t        in_action,
  input  wire logic [DATA_WIDTH-1:0]  in_push_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [DATA_WIDTH-1:0]  out_popped_word,
  output dq_pkg::status_t             out_status,
  output logic      [CNT_W-1:0]       out_occupancy
);
  import dq_pkg::*;

  // Number of stored words; cells 0 to count-1 hold the queue in order.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_popped_word_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_occupancy_r;

  logic in_accept;
  logic full;
  logic empty;
  status_t status;
  logic [DATA_WIDTH-1:0] popped_word;

  cell_ctrl_t            cell_ctrl [DEPTH];
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] tap_word  [DEPTH];

  // A request is taken whenever the result register is empty or drains now.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Request decode: status, new count and one control word for every cell.
  // Cell ops stay at hold unless a request is accepted and succeeds; pop taps do not wait for acceptance.
  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].op  = CELL_HOLD;
      cell_ctrl[i].tap = 1'b0;
    end
    case (in_action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else if (in_accept) begin
          count_nxt = count_r + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LFT;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else if (in_accept) begin
          count_nxt = count_r + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (count_r == CNT_W'(i)) cell_ctrl[i].op = CELL_LOAD;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cell_ctrl[0].tap = 1'b1;
          if (in_accept) begin
            count_nxt = count_r - 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              cell_ctrl[i].op = CELL_FROM_RGT;
            end
          end
        end
      end
      default: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          // The back word is read in place; no cell moves.
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].tap = (count_r == CNT_W'(i + 1));
          end
          if (in_accept) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
    endcase
  end

  // The chain: each cell sees its front-side and back-side neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (g == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[g+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_word  (left_word),
      .right_word (right_word),
      .push_word  (in_push_word),
      .word       (cell_word[g]),
      .tap_word   (tap_word[g])
    );
  end

  // At most one cell is tapped, so the pop read-out is a plain OR.
  always_comb begin
    popped_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      popped_word = popped_word | tap_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_popped_word_r <= popped_word;
      out_status_r      <= status;
      out_occupancy_r   <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_popped_word = out_popped_word_r;
  assign out_status      = out_status_r;
  assign out_occupancy   = out_occupancy_r;

  // The word count never runs past the number of cells.
  `DQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count exceeds depth")

  // A push on a full queue reports full and leaves the count alone.
  `DQ_ASSERT_NEXT(a_push_full,
    in_accept && full && (in_action == ACT_PUSH_FRONT || in_action == ACT_PUSH_BACK),
    out_status == ST_FULL && $stable(count_r), "push on full mishandled")

  // A successful pop lowers the count by exactly one.
  `DQ_ASSERT_NEXT(a_pop_count,
    in_accept && !empty && (in_action == ACT_POP_FRONT || in_action == ACT_POP_BACK),
    count_r == $past(count_r) - 1'b1, "pop count wrong")

  // A pending result always reports the current word count.
  `DQ_ASSERT_SAME(a_occ_track, out_valid_r, out_occupancy_r == count_r, "occupancy stale")

endmodule

`default_nettype wire
